### hw/rtl/pqem_pkg.sv
package pqem_pkg;

  // Command codes carried on cmd
  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_EXTRACT = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_NOP     = 2'd3
  } pqem_cmd_t;

  // Per-cycle operation broadcast to every cell of the row
  typedef struct packed {
    logic ins;
    logic ext;
  } pqem_ctl_t;

  localparam int CAP_BITS   = 5;
  localparam int COUNT_BITS = 5;

endpackage

### hw/rtl/priority_queue_extract_max.sv
// A result is registered in the output register in the cycle after its request is accepted.
// Throughput: one request per cycle while req_stall is low; each cell does one compare and
// one neighbor shift per request, so the rate does not depend on DEPTH or entry count.
// Back-pressure on the result side reaches req_stall while the output register is full.
// Reset (rst, synchronous): count 0, capacity 16, output register empty.
// Entry storage is not cleared; only entries below the count are ever read.
module priority_queue_extract_max #(
  parameter int DEPTH         = 16,
  parameter int PRIORITY_BITS = 8,
  parameter int PAYLOAD_BITS  = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_stall,
  input  logic [1:0]               cmd,
  input  logic [PAYLOAD_BITS-1:0]  payload,
  input  logic [PRIORITY_BITS-1:0] priority_req,
  output logic                     res_valid,
  input  logic                     res_stall,
  output logic                     out_valid,
  output logic [PAYLOAD_BITS-1:0]  out_payload,
  output logic                     insert_dropped,
  output logic [4:0]               entry_count,
  output logic                     is_empty,
  output logic                     is_full,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [4:0]               cfg_data
);
  import pqem_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

  logic [CNT_W-1:0]    count, count_next;
  logic [CAP_BITS-1:0] capacity;
  logic [CMP_W-1:0]    count_ext, count_next_ext, cap_ext, eff_cap;
  logic                accept, can_insert, has_entry;
  pqem_cmd_t           op;
  pqem_ctl_t           ctl;

  logic [DEPTH-1:0]                     move;
  logic [DEPTH-1:0][PRIORITY_BITS-1:0]  cell_pri;
  logic [DEPTH-1:0][PAYLOAD_BITS-1:0]   cell_pay;

  assign cfg_ready = 1'b1;
  assign req_stall = res_valid && res_stall;
  assign accept    = req_valid && !req_stall;
  assign op        = pqem_cmd_t'(cmd);

  assign count_ext  = CMP_W'(count);
  assign cap_ext    = CMP_W'(capacity);
  assign eff_cap    = (cap_ext > DEPTH_C) ? DEPTH_C : cap_ext;
  assign can_insert = (count_ext < eff_cap);
  assign has_entry  = (count != '0);

  always_comb begin
    ctl        = '0;
    count_next = count;
    case (op)
      CMD_INSERT: begin
        ctl.ins = accept && can_insert;
        if (can_insert) count_next = count + CNT_W'(1);
      end
      CMD_EXTRACT: begin
        ctl.ext = accept && has_entry;
        if (has_entry) count_next = count - CNT_W'(1);
      end
      CMD_CLEAR: count_next = '0;
      default:   count_next = count;
    endcase
  end

  assign count_next_ext = CMP_W'(count_next);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    logic                     lmove;
    logic [PRIORITY_BITS-1:0] lpri, rpri;
    logic [PAYLOAD_BITS-1:0]  lpay, rpay;

    if (i == 0) begin : g_head
      assign lmove = 1'b0;
      assign lpri  = priority_req;
      assign lpay  = payload;
    end else begin : g_body
      assign lmove = move[i-1];
      assign lpri  = cell_pri[i-1];
      assign lpay  = cell_pay[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign rpri = cell_pri[i];
      assign rpay = cell_pay[i];
    end else begin : g_mid
      assign rpri = cell_pri[i+1];
      assign rpay = cell_pay[i+1];
    end

    pqem_cell #(
      .PRIORITY_BITS(PRIORITY_BITS),
      .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .occupied (IDX < count),
      .new_pri  (priority_req),
      .new_pay  (payload),
      .left_move(lmove),
      .left_pri (lpri),
      .left_pay (lpay),
      .right_pri(rpri),
      .right_pay(rpay),
      .move     (move[i]),
      .pri      (cell_pri[i]),
      .pay      (cell_pay[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      capacity  <= CAP_BITS'(16);
      res_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) capacity <= cfg_data;
      if (accept) count <= count_next;
      if (accept) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Result fields; head cell always holds the highest-priority, oldest entry
  always_ff @(posedge clk) begin
    if (accept) begin
      out_valid      <= (op == CMD_EXTRACT) && has_entry;
      out_payload    <= ((op == CMD_EXTRACT) && has_entry) ? cell_pay[0] : '0;
      insert_dropped <= (op == CMD_INSERT) && !can_insert;
      entry_count    <= count_next_ext[COUNT_BITS-1:0];
      is_empty       <= (count_next == '0);
      is_full        <= (count_next_ext >= eff_cap);
    end
  end

endmodule

### hw/rtl/pqem_cell.sv
module pqem_cell #(
  parameter int PRIORITY_BITS = 8,
  parameter int PAYLOAD_BITS  = 16
) (
  input  logic                     clk,
  input  pqem_pkg::pqem_ctl_t      ctl,
  input  logic                     occupied,
  input  logic [PRIORITY_BITS-1:0] new_pri,
  input  logic [PAYLOAD_BITS-1:0]  new_pay,
  input  logic                     left_move,
  input  logic [PRIORITY_BITS-1:0] left_pri,
  input  logic [PAYLOAD_BITS-1:0]  left_pay,
  input  logic [PRIORITY_BITS-1:0] right_pri,
  input  logic [PAYLOAD_BITS-1:0]  right_pay,
  output logic                     move,
  output logic [PRIORITY_BITS-1:0] pri,
  output logic [PAYLOAD_BITS-1:0]  pay
);
  import pqem_pkg::*;

  logic [PRIORITY_BITS-1:0] pri_next;
  logic [PAYLOAD_BITS-1:0]  pay_next;

  // Row is kept sorted by priority, oldest first among equals. A cell gives
  // way to a new entry when it is free or holds a strictly lower priority.
  assign move = !occupied || (pri < new_pri);

  always_comb begin
    pri_next = pri;
    pay_next = pay;
    if (ctl.ins && move) begin
      if (left_move) begin
        pri_next = left_pri;
        pay_next = left_pay;
      end else begin
        pri_next = new_pri;
        pay_next = new_pay;
      end
    end else if (ctl.ext) begin
      pri_next = right_pri;
      pay_next = right_pay;
    end
  end

  always_ff @(posedge clk) begin
    pri <= pri_next;
    pay <= pay_next;
  end

endmodule

### hw/rtl/pqem_checker.sv
module pqem_checker #(
  parameter int PAYLOAD_BITS = 16
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    res_valid,
  input logic                    res_stall,
  input logic                    out_valid,
  input logic [PAYLOAD_BITS-1:0] out_payload,
  input logic                    insert_dropped,
  input logic [4:0]              entry_count,
  input logic                    is_empty,
  input logic                    is_full
);

  // Status fields must agree with each other
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (is_empty == (entry_count == 5'd0)))
    else $error("is_empty disagrees with entry_count");

  // A refused insert only happens with the queue at capacity
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (res_valid && insert_dropped) |-> (is_full && !out_valid))
    else $error("insert dropped while not full");

  // No entry returned means a zero handle
  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !out_valid) |-> (out_payload == '0))
    else $error("payload nonzero without an extracted entry");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(out_payload)
      && $stable(entry_count)))
    else $error("stalled result changed");

endmodule

bind priority_queue_extract_max pqem_checker #(.PAYLOAD_BITS(PAYLOAD_BITS)) u_pqem_checker (.*);
